// ===== sv/catrom_pkg.sv =====
`default_nettype none
package catrom_pkg;

	localparam int DEF_MAX_KEYS   = 64;
	localparam int DEF_MAX_DIM    = 4;
	localparam int DEF_VALUE_BITS = 16;

	localparam int TIME_BITS      = 16;
	localparam int KEY_INDEX_BITS = 6;
	localparam int KEY_COUNT_BITS = 7;
	localparam int DIM_BITS       = 3;
	localparam int CFG_INDEX_BITS = 4;
	localparam int CFG_DATA_BITS  = 7;
	localparam int OUT_LANES      = 4;

	// h is Q0.16; weights are Q16 signed
	localparam int FRAC_BITS   = 16;
	localparam int WEIGHT_BITS = 20;
	localparam int POLY_BITS   = 56;

	localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_COUNT = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DIMENSION = 4'd1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_K_INC,
		OP_LATCH_T1,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_H2,
		OP_H3,
		OP_WEIGHT,
		OP_MUL,
		OP_ACC,
		OP_OUT_KEY,
		OP_OUT_INTERP
	} op_t;

	typedef struct packed {
		op_t  op;
		logic set_clamp;
		logic rd_prev;   // time read at k-1 instead of k
		logic rd_kn;     // value read at clamped neighbor instead of k
	} cmd_t;

	typedef struct packed {
		logic t_lt;
		logic t_eq;
		logic k_last;
		logic k_zero;
		logic div_last;
		logic w_last;
		logic out_free;
	} sts_t;

	// Catmull-Rom basis, row = neighbor (k-2..k+1), col = power h^3..h^0
	function automatic logic signed [3:0] basis_coef(input logic [1:0] row,
		input logic [1:0] col);
		logic signed [3:0] c;
		c = 4'sd0;
		unique case ({row, col})
			4'h0: c = -4'sd1;
			4'h1: c = 4'sd2;
			4'h2: c = -4'sd1;
			4'h3: c = 4'sd0;
			4'h4: c = 4'sd3;
			4'h5: c = -4'sd5;
			4'h6: c = 4'sd0;
			4'h7: c = 4'sd2;
			4'h8: c = -4'sd3;
			4'h9: c = 4'sd4;
			4'hA: c = 4'sd1;
			4'hB: c = 4'sd0;
			4'hC: c = 4'sd1;
			4'hD: c = -4'sd1;
			4'hE: c = 4'sd0;
			4'hF: c = 4'sd0;
			default: c = 4'sd0;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== sv/catrom_ram.sv =====
`default_nettype none
module catrom_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== sv/catrom_ctrl.sv =====
`default_nettype none
module catrom_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              action,
	input  wire catrom_pkg::sts_t  sts,
	output catrom_pkg::cmd_t       cmd,
	output logic                   busy
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CHK,
		S_T0_RD,
		S_T0_CHK,
		S_DIV,
		S_H2,
		S_H3,
		S_W_RD,
		S_W_MUL,
		S_W_ACC,
		S_KEY_RD,
		S_KEY_OUT,
		S_INT_OUT
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_comb begin
		state_nx      = state_q;
		cmd.op        = catrom_pkg::OP_NONE;
		cmd.set_clamp = 1'b0;
		cmd.rd_prev   = 1'b0;
		cmd.rd_kn     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && action) begin
					cmd.op   = catrom_pkg::OP_CAPTURE;
					state_nx = S_SRCH_RD;
				end
			end
			S_SRCH_RD: state_nx = S_SRCH_CHK;
			S_SRCH_CHK: begin
				priority if (sts.t_lt && sts.k_last) begin
					cmd.set_clamp = 1'b1;
					state_nx      = S_KEY_RD;
				end else if (sts.t_lt) begin
					cmd.op   = catrom_pkg::OP_K_INC;
					state_nx = S_SRCH_RD;
				end else if (sts.t_eq) begin
					state_nx = S_KEY_RD;
				end else if (sts.k_zero) begin
					cmd.set_clamp = 1'b1;
					state_nx      = S_KEY_RD;
				end else begin
					cmd.op   = catrom_pkg::OP_LATCH_T1;
					state_nx = S_T0_RD;
				end
			end
			S_T0_RD: begin
				cmd.rd_prev = 1'b1;
				state_nx    = S_T0_CHK;
			end
			S_T0_CHK: begin
				cmd.op   = catrom_pkg::OP_DIV_INIT;
				state_nx = S_DIV;
			end
			S_DIV: begin
				cmd.op = catrom_pkg::OP_DIV_STEP;
				if (sts.div_last) begin
					state_nx = S_H2;
				end
			end
			S_H2: begin
				cmd.op   = catrom_pkg::OP_H2;
				state_nx = S_H3;
			end
			S_H3: begin
				cmd.op   = catrom_pkg::OP_H3;
				state_nx = S_W_RD;
			end
			S_W_RD: begin
				cmd.op    = catrom_pkg::OP_WEIGHT;
				cmd.rd_kn = 1'b1;
				state_nx  = S_W_MUL;
			end
			S_W_MUL: begin
				cmd.op   = catrom_pkg::OP_MUL;
				state_nx = S_W_ACC;
			end
			S_W_ACC: begin
				cmd.op   = catrom_pkg::OP_ACC;
				state_nx = sts.w_last ? S_INT_OUT : S_W_RD;
			end
			S_KEY_RD: state_nx = S_KEY_OUT;
			S_KEY_OUT: begin
				if (sts.out_free) begin
					cmd.op   = catrom_pkg::OP_OUT_KEY;
					state_nx = S_IDLE;
				end
			end
			S_INT_OUT: begin
				if (sts.out_free) begin
					cmd.op   = catrom_pkg::OP_OUT_INTERP;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule
`default_nettype wire

// ===== sv/catrom_dp.sv =====
`default_nettype none
module catrom_dp #(
	parameter int MAX_KEYS   = catrom_pkg::DEF_MAX_KEYS,
	parameter int MAX_DIM    = catrom_pkg::DEF_MAX_DIM,
	parameter int VALUE_BITS = catrom_pkg::DEF_VALUE_BITS
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire catrom_pkg::cmd_t                          cmd,
	output catrom_pkg::sts_t                               sts,
	input  wire logic                                      ld_we,
	input  wire logic [$clog2(MAX_KEYS)-1:0]               ld_addr,
	input  wire logic [catrom_pkg::TIME_BITS-1:0]          ld_time,
	input  wire logic [MAX_DIM*VALUE_BITS-1:0]             ld_vals,
	input  wire logic [catrom_pkg::TIME_BITS-1:0]          query_time,
	input  wire logic [catrom_pkg::KEY_COUNT_BITS-1:0]     key_count,
	input  wire logic [catrom_pkg::DIM_BITS-1:0]           dimension,
	input  wire logic                                      out_stall,
	output logic                                           out_valid,
	output logic [VALUE_BITS-1:0]                          result [catrom_pkg::OUT_LANES],
	output logic                                           clamped
);

	localparam int AW    = $clog2(MAX_KEYS);
	localparam int NW    = AW + 1;
	localparam int VW    = MAX_DIM * VALUE_BITS;
	localparam int TB    = catrom_pkg::TIME_BITS;
	localparam int FB    = catrom_pkg::FRAC_BITS;
	localparam int CB    = $clog2(FB);
	localparam int WB    = catrom_pkg::WEIGHT_BITS;
	localparam int PB    = WB + VALUE_BITS;
	localparam int ACCW  = PB + 2;
	localparam int POLY  = catrom_pkg::POLY_BITS;
	localparam int LANES = catrom_pkg::OUT_LANES;
	localparam int DB    = catrom_pkg::DIM_BITS;
	localparam logic signed [ACCW-1:0] SAT_HI = ACCW'((2 ** (VALUE_BITS - 1)) - 1);
	localparam logic signed [ACCW-1:0] SAT_LO = -SAT_HI - ACCW'(1);

	logic [TB-1:0]   t_q;
	logic [NW-1:0]   num_q;
	logic [DB-1:0]   dim_q;
	logic [AW-1:0]   k_q;
	logic [1:0]      i_q;
	logic [CB-1:0]   cnt_q;
	logic [TB-1:0]   t1_q;
	logic [TB-1:0]   den_q;
	logic [TB-1:0]   rem_q;
	logic [FB-1:0]   h_q;
	logic [2*FB-1:0] h2_q;
	logic [3*FB-1:0] h3_q;
	logic signed [WB-1:0]   w_q;
	logic signed [PB-1:0]   prod_q [LANES];
	logic signed [ACCW-1:0] acc_q  [LANES];
	logic            clamped_q;
	logic            out_valid_q;
	logic [VALUE_BITS-1:0] result_q [LANES];
	logic            clamped_out_q;

	logic [TB-1:0]   time_rdata;
	logic [VW-1:0]   val_rdata;
	logic [AW-1:0]   t_raddr;
	logic [AW-1:0]   v_raddr;
	logic [AW-1:0]   kn;
	logic [NW-1:0]   num_c;
	logic [DB-1:0]   dim_c;
	logic [TB:0]     rem2;
	logic            ge;
	logic signed [POLY-1:0] poly;
	logic signed [WB-1:0]   w_c;
	logic signed [VALUE_BITS-1:0] v_lane [LANES];
	logic [VALUE_BITS-1:0] r_int [LANES];

	catrom_ram #(.WIDTH(TB), .DEPTH(MAX_KEYS)) u_times (
		.clk    (clk),
		.we     (ld_we),
		.waddr  (ld_addr),
		.wdata  (ld_time),
		.raddr  (t_raddr),
		.rdata_q(time_rdata)
	);

	catrom_ram #(.WIDTH(VW), .DEPTH(MAX_KEYS)) u_values (
		.clk    (clk),
		.we     (ld_we),
		.waddr  (ld_addr),
		.wdata  (ld_vals),
		.raddr  (v_raddr),
		.rdata_q(val_rdata)
	);

	for (genvar j = 0; j < LANES; j++) begin : g_lane
		if (j < MAX_DIM) begin : g_used
			assign v_lane[j] = signed'(val_rdata[j*VALUE_BITS +: VALUE_BITS]);
		end else begin : g_unused
			assign v_lane[j] = '0;
		end
	end

	always_comb begin
		int kn_i;
		kn_i = int'(k_q) + int'(i_q) - 2;
		if (kn_i < 0) begin
			kn_i = 0;
		end else if (kn_i > int'(num_q) - 1) begin
			kn_i = int'(num_q) - 1;
		end
		kn = AW'(kn_i);
	end

	assign t_raddr = cmd.rd_prev ? (k_q - AW'(1)) : k_q;
	assign v_raddr = cmd.rd_kn ? kn : k_q;

	always_comb begin
		if (key_count == '0) begin
			num_c = NW'(1);
		end else if (int'(key_count) > MAX_KEYS) begin
			num_c = NW'(MAX_KEYS);
		end else begin
			num_c = NW'(key_count);
		end
		if (int'(dimension) > MAX_DIM) begin
			dim_c = DB'(MAX_DIM);
		end else begin
			dim_c = dimension;
		end
	end

	assign rem2 = {rem_q, 1'b0};
	assign ge   = (rem2 >= {1'b0, den_q});

	// weight = round(poly / 2) in Q16, poly in Q48
	always_comb begin
		logic signed [POLY-1:0] e3, e2, e1, e0;
		e3   = signed'(POLY'(h3_q));
		e2   = signed'(POLY'(h2_q)) <<< FB;
		e1   = signed'(POLY'(h_q)) <<< (2 * FB);
		e0   = signed'(POLY'(1)) <<< (3 * FB);
		poly = POLY'(catrom_pkg::basis_coef(i_q, 2'd0)) * e3
		     + POLY'(catrom_pkg::basis_coef(i_q, 2'd1)) * e2
		     + POLY'(catrom_pkg::basis_coef(i_q, 2'd2)) * e1
		     + POLY'(catrom_pkg::basis_coef(i_q, 2'd3)) * e0
		     + (signed'(POLY'(1)) <<< (2 * FB));
		w_c  = WB'(poly >>> (2 * FB + 1));
	end

	always_comb begin
		logic signed [ACCW-1:0] rs;
		for (int j = 0; j < LANES; j++) begin
			rs = (acc_q[j] + ACCW'(32768)) >>> FB;
			if (rs > SAT_HI) begin
				r_int[j] = VALUE_BITS'(SAT_HI);
			end else if (rs < SAT_LO) begin
				r_int[j] = VALUE_BITS'(SAT_LO);
			end else begin
				r_int[j] = VALUE_BITS'(rs);
			end
		end
	end

	assign sts.t_lt     = (time_rdata < t_q);
	assign sts.t_eq     = (time_rdata == t_q);
	assign sts.k_last   = (NW'(k_q) == num_q - NW'(1));
	assign sts.k_zero   = (k_q == '0);
	assign sts.div_last = (cnt_q == CB'(FB - 1));
	assign sts.w_last   = (i_q == 2'd3);
	assign sts.out_free = !out_valid_q || !out_stall;

	// control counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			i_q         <= '0;
			cnt_q       <= '0;
			clamped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == catrom_pkg::OP_OUT_KEY || cmd.op == catrom_pkg::OP_OUT_INTERP) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.set_clamp) begin
				clamped_q <= 1'b1;
			end
			unique case (cmd.op)
				catrom_pkg::OP_CAPTURE: begin
					k_q       <= '0;
					clamped_q <= 1'b0;
				end
				catrom_pkg::OP_K_INC:    k_q <= k_q + AW'(1);
				catrom_pkg::OP_DIV_INIT: begin
					cnt_q <= '0;
					i_q   <= '0;
				end
				catrom_pkg::OP_DIV_STEP: cnt_q <= cnt_q + CB'(1);
				catrom_pkg::OP_ACC:      i_q <= i_q + 2'd1;
				default: ;
			endcase
		end
	end

	// arithmetic
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			catrom_pkg::OP_CAPTURE: begin
				t_q   <= query_time;
				num_q <= num_c;
				dim_q <= dim_c;
			end
			catrom_pkg::OP_LATCH_T1: t1_q <= time_rdata;
			catrom_pkg::OP_DIV_INIT: begin
				rem_q <= t_q - time_rdata;
				den_q <= t1_q - time_rdata;
				h_q   <= '0;
				for (int j = 0; j < LANES; j++) begin
					acc_q[j] <= '0;
				end
			end
			catrom_pkg::OP_DIV_STEP: begin
				rem_q <= ge ? TB'(rem2 - {1'b0, den_q}) : TB'(rem2);
				h_q   <= {h_q[FB-2:0], ge};
			end
			catrom_pkg::OP_H2: h2_q <= (2 * FB)'(h_q) * (2 * FB)'(h_q);
			catrom_pkg::OP_H3: h3_q <= (3 * FB)'(h2_q) * (3 * FB)'(h_q);
			catrom_pkg::OP_WEIGHT: w_q <= w_c;
			catrom_pkg::OP_MUL: begin
				for (int j = 0; j < LANES; j++) begin
					prod_q[j] <= PB'(w_q) * PB'(v_lane[j]);
				end
			end
			catrom_pkg::OP_ACC: begin
				for (int j = 0; j < LANES; j++) begin
					acc_q[j] <= acc_q[j] + ACCW'(prod_q[j]);
				end
			end
			catrom_pkg::OP_OUT_KEY: begin
				clamped_out_q <= clamped_q;
				for (int j = 0; j < LANES; j++) begin
					result_q[j] <= (j < int'(dim_q)) ? VALUE_BITS'(v_lane[j]) : '0;
				end
			end
			catrom_pkg::OP_OUT_INTERP: begin
				clamped_out_q <= 1'b0;
				for (int j = 0; j < LANES; j++) begin
					result_q[j] <= (j < int'(dim_q)) ? r_int[j] : '0;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign clamped   = clamped_out_q;
	assign result    = result_q;

endmodule
`default_nettype wire

// ===== sv/catmull_rom_keyframe_interp_top.sv =====
// Catmull-Rom keyframe interpolator. Load: writes one key, no result. Query: the keys are read
// and checked one by one up to the stop index k; an end-key or exact-hit result follows that
// search, and an interpolated one also takes a serial divide for h, 2 power steps and a read,
// multiply and accumulate per weight. One item in flight, and a query waits while an earlier
// result is stalled. Reset (arst_n low, async): controller idle, key_count = 1, dimension = 1;
// key memories are not cleared and hold nothing until loaded.
`default_nettype none
module catmull_rom_keyframe_interp_top #(
	parameter int MAX_KEYS   = catrom_pkg::DEF_MAX_KEYS,
	parameter int MAX_DIM    = catrom_pkg::DEF_MAX_DIM,
	parameter int VALUE_BITS = catrom_pkg::DEF_VALUE_BITS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// input channel
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic                                  action,
	input  wire logic [catrom_pkg::KEY_INDEX_BITS-1:0] key_index,
	input  wire logic [catrom_pkg::TIME_BITS-1:0]      key_time,
	input  wire logic [VALUE_BITS-1:0]                 value_0,
	input  wire logic [VALUE_BITS-1:0]                 value_1,
	input  wire logic [VALUE_BITS-1:0]                 value_2,
	input  wire logic [VALUE_BITS-1:0]                 value_3,
	input  wire logic [catrom_pkg::TIME_BITS-1:0]      query_time,
	// result channel
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [VALUE_BITS-1:0]                      result_0,
	output logic [VALUE_BITS-1:0]                      result_1,
	output logic [VALUE_BITS-1:0]                      result_2,
	output logic [VALUE_BITS-1:0]                      result_3,
	output logic                                       clamped,
	// configuration writes
	input  wire logic                                  cfg_we,
	input  wire logic [catrom_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [catrom_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int AW    = $clog2(MAX_KEYS);
	localparam int LANES = catrom_pkg::OUT_LANES;

	logic [catrom_pkg::KEY_COUNT_BITS-1:0] key_count_q;
	logic [catrom_pkg::DIM_BITS-1:0]       dimension_q;

	catrom_pkg::cmd_t cmd;
	catrom_pkg::sts_t sts;
	logic busy;
	logic in_xfer;
	logic ld_we;
	logic [VALUE_BITS-1:0]         in_val [LANES];
	logic [MAX_DIM*VALUE_BITS-1:0] ld_vals;
	logic [VALUE_BITS-1:0]         result [LANES];

	// config registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= catrom_pkg::KEY_COUNT_BITS'(1);
			dimension_q <= catrom_pkg::DIM_BITS'(1);
		end else if (cfg_we) begin
			if (cfg_index == catrom_pkg::REG_KEY_COUNT) begin
				key_count_q <= cfg_data[catrom_pkg::KEY_COUNT_BITS-1:0];
			end else if (cfg_index == catrom_pkg::REG_DIMENSION) begin
				dimension_q <= cfg_data[catrom_pkg::DIM_BITS-1:0];
			end
		end
	end

	// only idle takes a transfer; loads finish in that same cycle
	assign in_stall = busy;
	assign in_xfer  = in_valid && !busy;
	// slots past the table are dropped
	assign ld_we    = in_xfer && !action && (int'(key_index) < MAX_KEYS);

	assign in_val[0] = value_0;
	assign in_val[1] = value_1;
	assign in_val[2] = value_2;
	assign in_val[3] = value_3;

	for (genvar j = 0; j < MAX_DIM; j++) begin : g_pack
		assign ld_vals[j*VALUE_BITS +: VALUE_BITS] = in_val[j];
	end

	catrom_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_xfer),
		.action  (action),
		.sts     (sts),
		.cmd     (cmd),
		.busy    (busy)
	);

	catrom_dp #(
		.MAX_KEYS  (MAX_KEYS),
		.MAX_DIM   (MAX_DIM),
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.ld_we     (ld_we),
		.ld_addr   (AW'(key_index)),
		.ld_time   (key_time),
		.ld_vals   (ld_vals),
		.query_time(query_time),
		.key_count (key_count_q),
		.dimension (dimension_q),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.result    (result),
		.clamped   (clamped)
	);

	assign result_0 = result[0];
	assign result_1 = result[1];
	assign result_2 = result[2];
	assign result_3 = result[3];

endmodule
`default_nettype wire
